>>> src/mov_edc_pkg.sv
// shared constants for the mov embedding degree check
`timescale 1ns / 1ps
package mov_edc_pkg;

  // fixed field widths of the stream items
  localparam int IDX_W    = 3;
  localparam int FIELD_W  = 64;
  localparam int IN_BITS  = IDX_W + 2 * FIELD_W;
  localparam int IN_BYTES = (IN_BITS + 7) / 8;
  localparam int IN_W     = IN_BYTES * 8;
  localparam int OUT_W    = 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT = 1'd1;
  localparam int CFG_DATA_W = 8;

  // reset values of the registers
  localparam logic [3:0] WORD_COUNT_RST  = 4'd4;
  localparam logic [7:0] POWER_LIMIT_RST = 8'd50;

endpackage

>>> src/mov_embedding_degree_check.sv
// top level of the mov embedding degree check
//
//  channel   dir  handshake            payload
//  s_axis    in   s_tvalid/s_tready    s_tdata: word_index, order_word, prime_word
//  m_axis    out  m_tvalid/m_tready    m_tdata: condition_met, bad_modulus
//  cfg       in   cfg_we               cfg_index, cfg_data
//
// Load items are taken only while idle; the item with the last index starts the check.
// All state sits in word-wide memories worked one word per cycle, a pass covering the
// n words. Each bit takes a shift pass, a subtract pass on overflow or when the result
// reaches the modulus, and in products an add pass with its own subtract pass: one to
// four passes per bit. Up to power_limit powers of p (at least one) are checked, the
// first by the reduction of p (one or two passes per bit); a zero modulus takes one pass.
// rst clears control and configuration registers only. A result waits in the output
// register; the next load item is still taken; the next check stalls only at its end.
`timescale 1ns / 1ps
module mov_embedding_degree_check #(
  parameter int MAX_WORDS = 8,
  parameter int WORD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  // word_index [2:0], order_word [66:3], prime_word [130:67]
  input  logic [mov_edc_pkg::IN_W-1:0]   s_tdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // condition_met [0], bad_modulus [1]
  output logic [mov_edc_pkg::OUT_W-1:0]  m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_we,
  input  logic [mov_edc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mov_edc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int BW = $clog2(WORD_BITS);
  localparam int W  = WORD_BITS;

  // controller states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_PASS  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // word-serial pass kinds
  localparam logic [2:0] OP_ZCHK  = 3'd0;
  localparam logic [2:0] OP_CLR   = 3'd1;
  localparam logic [2:0] OP_SHL   = 3'd2;
  localparam logic [2:0] OP_SUB_S = 3'd3;
  localparam logic [2:0] OP_ADD   = 3'd4;
  localparam logic [2:0] OP_SUB_A = 3'd5;
  localparam logic [2:0] OP_COPY  = 3'd6;

  // memories
  logic [W-1:0] ord_mem [MAX_WORDS];
  logic [W-1:0] pri_mem [MAX_WORDS];
  logic [W-1:0] res_mem [MAX_WORDS];
  logic [W-1:0] pow_mem [MAX_WORDS];
  logic [W-1:0] acc_mem [MAX_WORDS];
  logic [W-1:0] ord_rd, pri_rd, res_rd, pow_rd, acc_rd;

  // configuration
  logic [3:0] word_count;
  logic [7:0] power_limit;

  // control
  logic [1:0]    state;
  logic [2:0]    op;
  logic [CW-1:0] cnt;
  logic [IW-1:0] wi;
  logic [BW-1:0] bj;
  logic          phase_mul;
  logic [W-1:0]  bword;
  logic [7:0]    exponent_count;
  logic          carry, ge, flag;
  logic          out_met, out_bad;
  logic          fin_met, fin_bad;

  // input fields
  logic [mov_edc_pkg::IDX_W-1:0]   word_index;
  logic [mov_edc_pkg::FIELD_W-1:0] order_word, prime_word;
  assign word_index = s_tdata[mov_edc_pkg::IDX_W-1:0];
  assign order_word = s_tdata[mov_edc_pkg::IDX_W +: mov_edc_pkg::FIELD_W];
  assign prime_word = s_tdata[mov_edc_pkg::IDX_W + mov_edc_pkg::FIELD_W +: mov_edc_pkg::FIELD_W];

  // effective word count and limit
  logic [7:0]    n_wide;
  logic [CW-1:0] n_eff;
  logic [7:0]    lim_eff;
  logic [7:0]    idx_wide;
  always_comb begin
    n_wide = 8'(word_count);
    if (n_wide == 8'd0) n_wide = 8'd1;
    if (n_wide > 8'(MAX_WORDS)) n_wide = 8'(MAX_WORDS);
    n_eff   = n_wide[CW-1:0];
    lim_eff = (power_limit == 8'd0) ? 8'd1 : power_limit;
    idx_wide = 8'(word_index);
  end

  logic accept, in_range, last_word;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_range  = idx_wide < n_wide;
  assign last_word = idx_wide == (n_wide - 8'd1);

  // read address: the word index while fetching bits, else the pass counter
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] wr_idx;
  assign rd_idx = (state == ST_FETCH) ? wi : cnt[IW-1:0];
  assign wr_idx = IW'(cnt - CW'(1));

  // word processing of the current pass
  logic          first, proc, pass_end;
  logic          cin, ge_prev, flag_prev;
  logic [W-1:0]  rword;
  logic          cout, ge_new, flag_new;
  logic [W:0]    wide;
  logic          curbit;
  logic          need_sub;
  always_comb begin
    first     = (cnt == CW'(1));
    proc      = (state == ST_PASS) && (cnt != '0);
    pass_end  = (state == ST_PASS) && (cnt == n_eff);
    curbit    = bword[bj];
    ge_prev   = first ? 1'b1 : ge;
    flag_prev = first ? 1'b1 : flag;
    cin       = first ? ((op == OP_SHL) && !phase_mul && curbit) : carry;
    rword     = acc_rd;
    cout      = 1'b0;
    wide      = '0;
    flag_new  = flag_prev;
    case (op)
      OP_ZCHK: flag_new = flag_prev && (ord_rd == '0);
      OP_CLR:  rword = '0;
      OP_SHL: begin
        rword = {acc_rd[W-2:0], cin};
        cout  = acc_rd[W-1];
      end
      OP_ADD: begin
        wide  = {1'b0, acc_rd} + {1'b0, res_rd} + (W+1)'(cin);
        rword = wide[W-1:0];
        cout  = wide[W];
      end
      OP_SUB_S, OP_SUB_A: begin
        wide  = {1'b0, acc_rd} - {1'b0, ord_rd} - (W+1)'(cin);
        rword = wide[W-1:0];
        cout  = wide[W];
      end
      OP_COPY: flag_new = flag_prev && (acc_rd == (first ? W'(1) : W'(0)));
      default: rword = acc_rd;
    endcase
    ge_new   = (rword > ord_rd) || ((rword == ord_rd) && ge_prev);
    need_sub = cout || ge_new;
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      ord_mem[idx_wide[IW-1:0]] <= order_word[W-1:0];
      pri_mem[idx_wide[IW-1:0]] <= prime_word[W-1:0];
    end
    if (proc && op != OP_ZCHK && op != OP_COPY) acc_mem[wr_idx] <= rword;
    if (proc && op == OP_COPY) begin
      pow_mem[wr_idx] <= acc_rd;
      if (!phase_mul) res_mem[wr_idx] <= acc_rd;
    end
    ord_rd <= ord_mem[rd_idx];
    pri_rd <= pri_mem[rd_idx];
    res_rd <= res_mem[rd_idx];
    pow_rd <= pow_mem[rd_idx];
    acc_rd <= acc_mem[rd_idx];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count  <= mov_edc_pkg::WORD_COUNT_RST;
      power_limit <= mov_edc_pkg::POWER_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mov_edc_pkg::REG_WORD_COUNT:  word_count  <= cfg_data[3:0];
        mov_edc_pkg::REG_POWER_LIMIT: power_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      op             <= OP_ZCHK;
      cnt            <= '0;
      wi             <= '0;
      bj             <= '0;
      phase_mul      <= 1'b0;
      exponent_count <= '0;
      carry          <= 1'b0;
      ge             <= 1'b0;
      flag           <= 1'b0;
      m_tvalid       <= 1'b0;
      out_met        <= 1'b0;
      out_bad        <= 1'b0;
      fin_met        <= 1'b0;
      fin_bad        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FIN) m_tvalid <= 1'b0;
      if (proc) begin
        carry <= cout;
        ge    <= ge_new;
        flag  <= flag_new;
      end
      case (state)
        ST_IDLE: begin
          if (accept && in_range && last_word) begin
            state <= ST_PASS;
            op    <= OP_ZCHK;
            cnt   <= '0;
          end
        end
        ST_FETCH: begin
          if (cnt == '0) begin
            cnt <= CW'(1);
          end else begin
            bword <= phase_mul ? pow_rd : pri_rd;
            state <= ST_PASS;
            op    <= OP_SHL;
            cnt   <= '0;
          end
        end
        ST_PASS: begin
          if (!pass_end) begin
            cnt <= cnt + CW'(1);
          end else begin
            cnt <= '0;
            case (op)
              OP_ZCHK: begin
                if (flag_new) begin
                  fin_met        <= 1'b0;
                  fin_bad        <= 1'b1;
                  exponent_count <= '0;
                  state          <= ST_FIN;
                end else begin
                  phase_mul      <= 1'b0;
                  exponent_count <= 8'd1;
                  op             <= OP_CLR;
                end
              end
              OP_CLR: begin
                wi    <= IW'(n_eff - CW'(1));
                bj    <= BW'(W - 1);
                state <= ST_FETCH;
              end
              OP_COPY: begin
                if (flag_new || exponent_count >= lim_eff) begin
                  fin_met <= !flag_new;
                  fin_bad <= 1'b0;
                  state   <= ST_FIN;
                end else begin
                  exponent_count <= exponent_count + 8'd1;
                  phase_mul      <= 1'b1;
                  op             <= OP_CLR;
                end
              end
              default: begin
                // shift, add and their reductions
                if ((op == OP_SHL || op == OP_ADD) && need_sub) begin
                  op <= (op == OP_SHL) ? OP_SUB_S : OP_SUB_A;
                end else if ((op == OP_SHL || op == OP_SUB_S) && phase_mul && curbit) begin
                  op <= OP_ADD;
                end else if (bj != '0) begin
                  bj <= bj - BW'(1);
                  op <= OP_SHL;
                end else if (wi != '0) begin
                  wi    <= wi - IW'(1);
                  bj    <= BW'(W - 1);
                  state <= ST_FETCH;
                end else begin
                  op <= OP_COPY;
                end
              end
            endcase
          end
        end
        ST_FIN: begin
          // hand the verdict over once the output register is free
          if (!m_tvalid || m_tready) begin
            out_met  <= fin_met;
            out_bad  <= fin_bad;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'd0, out_bad, out_met};

endmodule
